// ----- rtl/square_matrix_rotator_unit_macros.svh -----
// Assertion macros used by the rotator back end.
`ifndef SQUARE_MATRIX_ROTATOR_UNIT_MACROS_SVH
`define SQUARE_MATRIX_ROTATOR_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SMR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smr: same-cycle check failed");
`define SMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smr: next-cycle check failed");
`else
`define SMR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SMR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/smr_pkg.sv -----
// Types, codes and constants of the square matrix rotator.
package smr_pkg;
    localparam int unsigned MAX_SIDE_DEF = 8;
    localparam int unsigned CFG_W        = 4;
    localparam int unsigned RC_W         = 3;
    localparam int unsigned VAL_W        = 32;
    localparam int unsigned CMDQ_DEPTH   = 4;
    localparam int unsigned OUTQ_DEPTH   = 4;
    localparam logic [CFG_W-1:0] SIZE_RESET = 4'd8;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_ROT_R = 2'd1,
        OP_ROT_L = 2'd2,
        OP_PRINT = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]              opcode;
        logic signed [VAL_W-1:0] element_value;
    } t_in_word;

    typedef struct packed {
        logic                    status;
        logic [RC_W-1:0]         out_row;
        logic [RC_W-1:0]         out_col;
        logic signed [VAL_W-1:0] out_value;
        logic                    last;
    } t_out_word;

    typedef struct packed {
        t_op              op;
        logic [VAL_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_hs;
endpackage

// ----- rtl/smr_front.sv -----
// Front end: accepts input words, classifies the opcode and queues commands.
module smr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  smr_pkg::t_in_word i_in,
    output logic              o_full,
    output smr_pkg::t_cmd_hs  o_cmd,
    input  logic              i_cmd_ready
);
    import smr_pkg::*;

    localparam int unsigned QAW = $clog2(CMDQ_DEPTH);
    localparam int unsigned QCW = $clog2(CMDQ_DEPTH + 1);

    t_cmd           r_q [CMDQ_DEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QCW-1:0] r_cnt;
    t_cmd           w_cmd;
    logic           w_push;
    logic           w_pop;

    always_comb begin
        w_cmd.op    = t_op'(i_in.opcode);
        w_cmd.value = i_in.element_value;
    end

    assign o_full      = (r_cnt == QCW'(CMDQ_DEPTH));
    assign w_push      = i_push && !o_full;
    assign o_cmd.valid = (r_cnt != '0);
    assign o_cmd.cmd   = r_q[r_rd];
    assign w_pop       = o_cmd.valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            r_cnt <= r_cnt + QCW'(w_push) - QCW'(w_pop);
        end
    end
endmodule

// ----- rtl/smr_back.sv -----
// Back end: element store, orientation, print sequencer and result queue.
`include "square_matrix_rotator_unit_macros.svh"
module smr_back #(
    parameter int unsigned MAX_SIDE = smr_pkg::MAX_SIDE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [smr_pkg::CFG_W-1:0] i_size,
    input  smr_pkg::t_cmd_hs         i_cmd,
    output logic                     o_cmd_ready,
    input  logic                     i_pop,
    output logic                     o_empty,
    output smr_pkg::t_out_word       o_out
);
    import smr_pkg::*;

    localparam int unsigned DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = $clog2(DEPTH + 1);
    localparam int unsigned SW    = $clog2(MAX_SIDE + 1);
    localparam int unsigned OAW   = $clog2(OUTQ_DEPTH);
    localparam int unsigned OCW   = $clog2(OUTQ_DEPTH + 1);
    localparam int unsigned OCW1  = OCW + 1;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_PRINT = 2'b10
    } t_state;

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rd_data;

    t_state          r_state, n_state;
    logic [RC_W-1:0] r_i, n_i;
    logic [RC_W-1:0] r_j, n_j;
    logic [1:0]      r_orient, n_orient;
    logic [CW-1:0]   r_ptr, n_ptr;
    logic            r_loaded, n_loaded;

    logic            r_p_valid;
    logic            r_p_status;
    logic [RC_W-1:0] r_p_row;
    logic [RC_W-1:0] r_p_col;
    logic            r_p_last;

    t_out_word       r_oq [OUTQ_DEPTH];
    logic [OAW-1:0]  r_owr;
    logic [OAW-1:0]  r_ord;
    logic [OCW-1:0]  r_ocnt;

    logic [SW-1:0]   w_side;
    logic [SW-1:0]   w_side_m1;
    logic [RC_W-1:0] w_last_rc;
    logic [2*SW-1:0] w_side_sq;
    logic [CW-1:0]   w_total;
    logic [CW-1:0]   w_lp;
    logic [CW-1:0]   w_lp1;
    logic [OCW:0]    w_used;
    logic            w_space;
    logic            w_take;
    logic            w_wr_en;
    logic            w_issue;
    logic            w_issue_status;
    logic [RC_W-1:0] w_r;
    logic [RC_W-1:0] w_c;
    logic [AW-1:0]   w_rd_addr;
    logic            w_pop;
    t_out_word       w_res;

    always_comb begin
        if (i_size == '0) begin
            w_side = SW'(1);
        end else if (i_size > CFG_W'(MAX_SIDE)) begin
            w_side = SW'(MAX_SIDE);
        end else begin
            w_side = SW'(i_size);
        end
    end

    assign w_side_m1 = w_side - SW'(1);
    assign w_last_rc = RC_W'(w_side_m1);
    assign w_side_sq = {{SW{1'b0}}, w_side} * {{SW{1'b0}}, w_side};
    assign w_total   = w_side_sq[CW-1:0];

    assign w_lp  = (r_ptr >= w_total) ? '0 : r_ptr;
    assign w_lp1 = w_lp + CW'(1);

    assign w_used  = {1'b0, r_ocnt} + {{OCW{1'b0}}, r_p_valid};
    assign w_space = (w_used < OCW1'(OUTQ_DEPTH));

    assign o_cmd_ready = (r_state == ST_IDLE) && ((i_cmd.cmd.op == OP_LOAD) || w_space);
    assign w_take      = i_cmd.valid && o_cmd_ready;

    always_comb begin
        n_state        = r_state;
        n_i            = r_i;
        n_j            = r_j;
        n_orient       = r_orient;
        n_ptr          = r_ptr;
        n_loaded       = r_loaded;
        w_wr_en        = 1'b0;
        w_issue        = 1'b0;
        w_issue_status = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    unique case (i_cmd.cmd.op)
                        OP_LOAD: begin
                            w_wr_en = 1'b1;
                            if (w_lp == '0) begin
                                n_orient = '0;
                            end
                            if (w_lp1 >= w_total) begin
                                n_ptr    = '0;
                                n_loaded = 1'b1;
                            end else begin
                                n_ptr = w_lp1;
                            end
                        end
                        OP_ROT_R: begin
                            if (r_loaded) begin
                                n_orient = r_orient + 2'd1;
                            end else begin
                                w_issue        = 1'b1;
                                w_issue_status = 1'b1;
                            end
                        end
                        OP_ROT_L: begin
                            if (r_loaded) begin
                                n_orient = r_orient - 2'd1;
                            end else begin
                                w_issue        = 1'b1;
                                w_issue_status = 1'b1;
                            end
                        end
                        OP_PRINT: begin
                            if (r_loaded) begin
                                n_state = ST_PRINT;
                                n_i     = '0;
                                n_j     = '0;
                            end else begin
                                w_issue        = 1'b1;
                                w_issue_status = 1'b1;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PRINT: begin
                if (w_space) begin
                    w_issue = 1'b1;
                    if (r_j == w_last_rc) begin
                        n_j = '0;
                        if (r_i == w_last_rc) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_i = r_i + RC_W'(1);
                        end
                    end else begin
                        n_j = r_j + RC_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        unique case (r_orient)
            2'd0: begin
                w_r = r_i;
                w_c = r_j;
            end
            2'd1: begin
                w_r = w_last_rc - r_j;
                w_c = r_i;
            end
            2'd2: begin
                w_r = w_last_rc - r_i;
                w_c = w_last_rc - r_j;
            end
            default: begin
                w_r = r_j;
                w_c = w_last_rc - r_i;
            end
        endcase
    end

    assign w_rd_addr = AW'(w_r) * AW'(w_side) + AW'(w_c);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_lp[AW-1:0]] <= i_cmd.cmd.value;
        end
        if (w_issue) begin
            r_rd_data  <= r_mem[w_rd_addr];
            r_p_status <= w_issue_status;
            r_p_row    <= w_issue_status ? '0 : r_i;
            r_p_col    <= w_issue_status ? '0 : r_j;
            r_p_last   <= w_issue_status || ((r_i == w_last_rc) && (r_j == w_last_rc));
        end
    end

    always_comb begin
        w_res.status    = r_p_status;
        w_res.out_row   = r_p_row;
        w_res.out_col   = r_p_col;
        w_res.out_value = r_p_status ? '0 : r_rd_data;
        w_res.last      = r_p_last;
    end

    assign o_empty = (r_ocnt == '0);
    assign o_out   = r_oq[r_ord];
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (r_p_valid) begin
            r_oq[r_owr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_i       <= '0;
            r_j       <= '0;
            r_orient  <= '0;
            r_ptr     <= '0;
            r_loaded  <= 1'b0;
            r_p_valid <= 1'b0;
            r_owr     <= '0;
            r_ord     <= '0;
            r_ocnt    <= '0;
        end else begin
            r_state   <= n_state;
            r_i       <= n_i;
            r_j       <= n_j;
            r_orient  <= n_orient;
            r_ptr     <= n_ptr;
            r_loaded  <= n_loaded;
            r_p_valid <= w_issue;
            if (r_p_valid) begin
                r_owr <= r_owr + OAW'(1);
            end
            if (w_pop) begin
                r_ord <= r_ord + OAW'(1);
            end
            r_ocnt <= r_ocnt + OCW'(r_p_valid) - OCW'(w_pop);
        end
    end

    `SMR_ASSERT_IMP(a_outq_room, i_clk, i_rst_n, 1'b1, w_used <= OCW1'(OUTQ_DEPTH))
    `SMR_ASSERT_IMP(a_ptr_range, i_clk, i_rst_n, 1'b1, r_ptr < CW'(DEPTH))
    `SMR_ASSERT_NEXT(a_orient_hold, i_clk, i_rst_n, r_state == ST_PRINT, r_orient == $past(r_orient))
    `SMR_ASSERT_NEXT(a_loaded_sticky, i_clk, i_rst_n, r_loaded, r_loaded)
endmodule

// ----- rtl/square_matrix_rotator_unit.sv -----
// Top level of the square matrix rotator: size register, front end and back end.
// Holds one n-by-n matrix of signed 32-bit elements (n from the size register, 1 to
// MAX_SIDE) and turns it by quarter turns without moving data: reads are remapped
// through a 2-bit orientation. Input words enter a 4-deep command queue; the back end
// executes one command at a time. A print reads one element a cycle, while the result
// queue has room, from the single read port of the element store; the read data is
// registered before each word enters the 4-deep result queue. A rotate or print before
// any complete load yields one status word. Write the size register only while the
// block is idle.
module square_matrix_rotator_unit #(
    parameter int unsigned MAX_SIDE = smr_pkg::MAX_SIDE_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  smr_pkg::t_in_word         i_in,
    output logic                      empty,
    input  logic                      pop,
    output smr_pkg::t_out_word        o_out,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [smr_pkg::CFG_W-1:0] i_cfg_data
);
    import smr_pkg::*;

    logic [CFG_W-1:0] r_matrix_size;
    t_cmd_hs          w_cmd;
    logic             w_cmd_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_matrix_size <= i_cfg_data;
        end
    end

    smr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_in        (i_in),
        .o_full      (full),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    smr_back #(
        .MAX_SIDE (MAX_SIDE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_size      (r_matrix_size),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out       (o_out)
    );
endmodule
